@@ rtl/wgv_pkg.sv @@
// shared constants, tables and helpers of the wind gust vector field unit
`default_nettype none
package wgv_pkg;

	localparam int OCTAVES = 3;
	localparam int NHORNER = 5;

	typedef logic [2:0][31:0] vec3_t;

	// configuration register indexes
	localparam logic [2:0] CFG_DIR_X    = 3'd0;
	localparam logic [2:0] CFG_DIR_Y    = 3'd1;
	localparam logic [2:0] CFG_DIR_Z    = 3'd2;
	localparam logic [2:0] CFG_STRENGTH = 3'd3;
	localparam logic [2:0] CFG_GUST     = 3'd4;
	localparam logic [2:0] CFG_SEED     = 3'd5;

	localparam logic [30:0] ONE_Q30      = 31'd1073741824;
	localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
	localparam logic [29:0] INV_TWO_PI   = 30'd683565276;
	localparam logic [30:0] Y_LIMIT_Q30  = 31'd1063004406;
	localparam logic [16:0] GUST_ONE     = 17'd65536;

	// spatial frequencies in turns, Q0.32
	localparam logic [29:0] FREQ [0:7][0:2] = '{
		'{30'd88863486,  30'd34178264,  30'd143548708},
		'{30'd252919152, 30'd75192180,  30'd198233930},
		'{30'd485331346, 30'd129877402, 30'd362289596},
		'{30'd0, 30'd0, 30'd0}, '{30'd0, 30'd0, 30'd0}, '{30'd0, 30'd0, 30'd0},
		'{30'd0, 30'd0, 30'd0}, '{30'd0, 30'd0, 30'd0}
	};
	localparam logic [31:0] SPEED [0:7] = '{
		32'd751921803, 32'd1572200134, 32'd2529191520,
		32'd0, 32'd0, 32'd0, 32'd0, 32'd0
	};
	localparam logic [15:0] AMP [0:7] = '{
		16'd32768, 16'd19661, 16'd13107, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
	};

	// horner divisors 110, 72, 42, 20, 6 as reciprocal multiply and shift
	localparam int HD_S [0:NHORNER-1] = '{39, 39, 38, 37, 35};
	localparam logic [32:0] HD_M [0:NHORNER-1] = '{
		33'(((65'd1 << 39) + 65'd109) / 65'd110),
		33'(((65'd1 << 39) + 65'd71) / 65'd72),
		33'(((65'd1 << 38) + 65'd41) / 65'd42),
		33'(((65'd1 << 37) + 65'd19) / 65'd20),
		33'(((65'd1 << 35) + 65'd5) / 65'd6)
	};

	// round to nearest, ties away from zero
	function automatic logic signed [71:0] rshr(input logic signed [71:0] v,
			input int unsigned sh);
		logic [71:0] mag;
		logic [71:0] r;
		mag = v[71] ? 72'(-v) : 72'(v);
		r = (mag + (72'd1 << (sh - 1))) >> sh;
		return v[71] ? -$signed(r) : $signed(r);
	endfunction

endpackage
`default_nettype wire

@@ rtl/wgv_norm.sv @@
// sequential vector normalizer: prescale, sum of squares, bit serial root and divide
`default_nettype none
module wgv_norm (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire wgv_pkg::vec3_t vec,
	output logic                done,
	output wgv_pkg::vec3_t      unit
);
	import wgv_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SHIFT = 3'd1;
	localparam logic [2:0] ST_SQ    = 3'd2;
	localparam logic [2:0] ST_SQRT  = 3'd3;
	localparam logic [2:0] ST_DLOAD = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;

	logic [2:0]  state_q;
	logic [4:0]  cnt_q;
	logic [1:0]  idx_q;
	logic        done_q;
	logic [31:0] m_q [0:2];
	logic [2:0]  neg_q;
	logic [63:0] n_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic [31:0] s_q;
	logic [31:0] rem_q;
	logic [30:0] lo_q;
	logic [30:0] quo_q;
	vec3_t       unit_q;

	logic [31:0] a [0:2];
	logic        all_zero;
	logic        big;
	logic [63:0] rb;
	logic [61:0] num;
	logic [32:0] rem2;
	logic        qb;
	logic [31:0] rem_n;
	logic [30:0] quo_n;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a[i] = vec[i][31] ? 32'(-$signed(vec[i])) : vec[i];
		end
		all_zero = (vec[0] == 32'd0) && (vec[1] == 32'd0) && (vec[2] == 32'd0);
		big = (|m_q[0][31:30]) | (|m_q[1][31:30]) | (|m_q[2][31:30]);
		rb = r_q + bit_q;
		num = {m_q[idx_q], 30'd0} + 62'(r_q[31:0] >> 1);
		rem2 = {rem_q, lo_q[30]};
		qb = rem2 >= {1'b0, s_q};
		rem_n = qb ? 32'(rem2 - {1'b0, s_q}) : rem2[31:0];
		quo_n = {quo_q[29:0], qb};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			idx_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (all_zero) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					if (big) begin
						state_q <= ST_SQ;
						idx_q <= '0;
					end
				end
				ST_SQ: begin
					if (idx_q == 2'd2) begin
						state_q <= ST_SQRT;
						cnt_q <= '0;
					end else begin
						idx_q <= idx_q + 2'd1;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= ST_DLOAD;
						idx_q <= '0;
					end
				end
				ST_DLOAD: begin
					state_q <= ST_DIV;
					cnt_q <= '0;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd30) begin
						if (idx_q == 2'd2) begin
							state_q <= ST_IDLE;
							done_q <= 1'b1;
						end else begin
							state_q <= ST_DLOAD;
							idx_q <= idx_q + 2'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				for (int i = 0; i < 3; i++) begin
					m_q[i] <= a[i];
					neg_q[i] <= vec[i][31];
				end
				n_q <= '0;
				if (start && all_zero) begin
					unit_q <= {32'd0, 32'd0, 32'(ONE_Q30)};
				end
			end
			ST_SHIFT: begin
				if (!big) begin
					for (int i = 0; i < 3; i++) begin
						m_q[i] <= {m_q[i][30:0], 1'b0};
					end
				end
			end
			ST_SQ: begin
				n_q <= n_q + 64'(m_q[idx_q]) * 64'(m_q[idx_q]);
				r_q <= '0;
				bit_q <= 64'd1 << 62;
			end
			ST_SQRT: begin
				if (n_q >= rb) begin
					n_q <= n_q - rb;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_DLOAD: begin
				if (idx_q == 2'd0) begin
					s_q <= r_q[31:0];
				end
				rem_q <= {1'b0, num[61:31]};
				lo_q <= num[30:0];
				quo_q <= '0;
			end
			ST_DIV: begin
				rem_q <= rem_n;
				lo_q <= {lo_q[29:0], 1'b0};
				quo_q <= quo_n;
				if (cnt_q == 5'd30) begin
					unit_q[idx_q] <= neg_q[idx_q] ? 32'(-$signed({1'b0, quo_n}))
						: {1'b0, quo_n};
				end
			end
			default: begin
				n_q <= n_q;
			end
		endcase
	end

	// first quotient load uses the root while it still sits in r_q
	assign done = done_q;
	assign unit = unit_q;

endmodule
`default_nettype wire

@@ rtl/wgv_sine.sv @@
// pipelined sine of a Q0.32 turn, odd polynomial in horner form, Q2.30 result
`default_nettype none
module wgv_sine (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic        [31:0] turn,
	output logic signed      [31:0] sin
);
	import wgv_pkg::*;

	localparam int LAST = 2 * NHORNER + 1;

	logic [1:0]  q_s  [0:LAST];
	logic [30:0] x_s  [0:LAST];
	logic [31:0] x2_s [1:2*NHORNER-1];
	logic [31:0] p_s  [0:NHORNER-1];
	logic [30:0] acc_s [0:NHORNER-1];
	logic signed [31:0] y_s;

	logic [30:0] r0;
	logic [60:0] xp0;
	logic [61:0] x2p;
	logic [61:0] yp;
	logic [32:0] yr;
	logic [31:0] yc;

	always_comb begin
		r0 = turn[30] ? ONE_Q30 - {1'b0, turn[29:0]} : {1'b0, turn[29:0]};
		xp0 = 61'(r0) * 61'(HALF_PI_Q30);
		x2p = 62'(x_s[0]) * 62'(x_s[0]);
		yp = 62'(x_s[LAST]) * 62'(acc_s[NHORNER-1]);
		yr = 33'((yp + (62'd1 << 29)) >> 30);
		yc = (yr > 33'(ONE_Q30)) ? 32'(ONE_Q30) : yr[31:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s[0] <= turn[31:30];
			x_s[0] <= 31'((xp0 + (61'd1 << 29)) >> 30);
			x2_s[1] <= 32'((x2p + (62'd1 << 29)) >> 30);
			for (int k = 1; k <= LAST; k++) begin
				q_s[k] <= q_s[k-1];
				x_s[k] <= x_s[k-1];
			end
			for (int k = 2; k <= 2 * NHORNER - 1; k++) begin
				x2_s[k] <= x2_s[k-1];
			end
			y_s <= q_s[LAST][1] ? -$signed(yc) : $signed(yc);
		end
	end

	for (genvar i = 0; i < NHORNER; i++) begin : g_step
		logic [30:0] acc_in;
		logic [62:0] pp;
		logic [65:0] dp;
		if (i == 0) begin : g_first
			assign acc_in = ONE_Q30;
		end else begin : g_next
			assign acc_in = acc_s[i-1];
		end
		assign pp = 63'(x2_s[1+2*i]) * 63'(acc_in);
		assign dp = 66'(p_s[i]) * 66'(HD_M[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				p_s[i] <= 32'((pp + (63'd1 << 29)) >> 30);
				acc_s[i] <= ONE_Q30 - 31'(dp >> HD_S[i]);
			end
		end
	end

	assign sin = y_s;

endmodule
`default_nettype wire

@@ rtl/wind_gust_vector_field_unit.sv @@
// top level of the wind gust vector field unit: config, direction setup and datapath
//
// channel  dir  fields (lsb first)                          handshake
// s_*      in   pos_x, pos_y, pos_z, sample_time (4x32)     s_tvalid/s_tready
// m_*      out  wind_x, wind_y, wind_z (3x32)               m_tvalid/m_tready
// cfg_*    in   register index, 32 bit data                 cfg_we, no wait
//
// one item per cycle while the output register is taken and no direction update is pending
// the whole pipeline advances together; a full output register
// that is not taken freezes every stage
// a direction write starts two normalizer passes, and s_tready
// stays low until both unit vectors are ready
// reset loads the default direction +x and its sideways vector +z directly
`default_nettype none
module wind_gust_vector_field_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,  // pos_x, pos_y, pos_z, sample_time
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [95:0]       m_tdata,  // wind_x, wind_y, wind_z
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_idx,
	input  wire logic [31:0]  cfg_data
);
	import wgv_pkg::*;

	localparam int NSTG = 20;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_UNIT = 2'd1;
	localparam logic [1:0] PH_SIDE = 2'd2;

	// configuration
	logic [31:0] dir_x_q, dir_y_q, dir_z_q, seed_q;
	logic [15:0] str_q;
	logic [16:0] gust_q;
	logic [47:0] seed_ph_q;
	logic [32:0] swing_q;

	// direction setup
	logic [1:0] phase_q;
	logic       dirty_q;
	vec3_t      u_q, w_q;
	logic       n_start;
	vec3_t      n_vec;
	logic       n_done;
	vec3_t      n_unit;
	vec3_t      side;
	logic [31:0] uy_abs;

	logic en;
	logic acc_in;
	logic [NSTG:1] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_x_q <= 32'd65536;
			dir_y_q <= '0;
			dir_z_q <= '0;
			str_q <= 16'd256;
			gust_q <= '0;
			seed_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_DIR_X:    dir_x_q <= cfg_data;
				CFG_DIR_Y:    dir_y_q <= cfg_data;
				CFG_DIR_Z:    dir_z_q <= cfg_data;
				CFG_STRENGTH: str_q <= cfg_data[15:0];
				CFG_GUST:     gust_q <= cfg_data[16:0];
				CFG_SEED:     seed_q <= cfg_data;
				default:      seed_q <= seed_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		seed_ph_q <= 48'($signed(seed_q) * $signed({1'b0, INV_TWO_PI}));
		swing_q <= 33'(str_q) * 33'((gust_q > GUST_ONE) ? GUST_ONE : gust_q);
	end

	always_comb begin
		uy_abs = n_unit[1][31] ? 32'(-$signed(n_unit[1])) : n_unit[1];
		if (uy_abs < 32'(Y_LIMIT_Q30)) begin
			side = {n_unit[0], 32'd0, 32'(-$signed(n_unit[2]))};
		end else begin
			side = {32'(-$signed(n_unit[1])), n_unit[2], 32'd0};
		end
		n_start = 1'b0;
		n_vec = {dir_z_q, dir_y_q, dir_x_q};
		priority case (1'b1)
			(phase_q == PH_IDLE) && dirty_q: n_start = 1'b1;
			(phase_q == PH_UNIT) && n_done: begin
				n_start = 1'b1;
				n_vec = side;
			end
			default: n_start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			dirty_q <= 1'b0;
			u_q <= {32'd0, 32'd0, 32'(ONE_Q30)};
			w_q <= {32'(ONE_Q30), 32'd0, 32'd0};
		end else begin
			unique case (phase_q)
				PH_IDLE: if (dirty_q) phase_q <= PH_UNIT;
				PH_UNIT: begin
					if (n_done) begin
						u_q <= n_unit;
						phase_q <= PH_SIDE;
					end
				end
				PH_SIDE: begin
					if (n_done) begin
						w_q <= n_unit;
						phase_q <= PH_IDLE;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
			if (cfg_we && (cfg_idx == CFG_DIR_X || cfg_idx == CFG_DIR_Y
					|| cfg_idx == CFG_DIR_Z)) begin
				dirty_q <= 1'b1;
			end else if (phase_q == PH_IDLE) begin
				dirty_q <= 1'b0;
			end
		end
	end

	wgv_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (n_start),
		.vec    (n_vec),
		.done   (n_done),
		.unit   (n_unit)
	);

	// pipeline control
	assign en = !m_tvalid || m_tready;
	assign s_tready = en && !dirty_q && (phase_q == PH_IDLE);
	assign acc_in = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			vld_s <= {vld_s[NSTG-1:1], acc_in};
			m_tvalid <= vld_s[NSTG];
		end
	end

	// stage 1 and 2: phase angles in turns, modulo one turn by wrap
	logic [47:0] pp_s1 [0:OCTAVES-1][0:2];
	logic [47:0] tp_s1 [0:OCTAVES-1];
	logic [31:0] tra_s2 [0:OCTAVES-1];
	logic [31:0] trc_s2 [0:OCTAVES-1];
	logic signed [31:0] sa_s15 [0:OCTAVES-1];
	logic signed [31:0] sc_s15 [0:OCTAVES-1];
	logic signed [48:0] ma_s16 [0:OCTAVES-1];
	logic signed [48:0] mc_s16 [0:OCTAVES-1];

	for (genvar k = 0; k < OCTAVES; k++) begin : g_oct
		logic [47:0] ang;
		assign ang = seed_ph_q + pp_s1[k][0] + pp_s1[k][1] + pp_s1[k][2] + tp_s1[k];
		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 3; j++) begin
					pp_s1[k][j] <= 48'($signed(s_tdata[32*j +: 32])
						* $signed({1'b0, FREQ[k][j]}));
				end
				tp_s1[k] <= 48'(64'(s_tdata[127:96]) * 64'(SPEED[k]));
				tra_s2[k] <= ang[47:16];
				trc_s2[k] <= ang[47:16] + 32'h4000_0000;
				ma_s16[k] <= $signed({1'b0, AMP[k]}) * sa_s15[k];
				mc_s16[k] <= $signed({1'b0, AMP[k]}) * sc_s15[k];
			end
		end
		wgv_sine u_sin_a (.clk(clk), .en(en), .turn(tra_s2[k]), .sin(sa_s15[k]));
		wgv_sine u_sin_c (.clk(clk), .en(en), .turn(trc_s2[k]), .sin(sc_s15[k]));
	end

	// gust sums, swing terms, vector accumulation
	logic signed [71:0] sum_a, sum_c;
	logic signed [31:0] along_s17, cross_s17;
	logic signed [33:0] ta_s18;
	logic signed [32:0] tc_s18;
	logic signed [48:0] a_s19 [0:2];
	logic signed [65:0] b_s19 [0:2];
	logic signed [64:0] c_s19 [0:2];
	logic signed [57:0] acc_s20 [0:2];
	logic signed [71:0] res [0:2];
	logic [31:0] sat [0:2];

	always_comb begin
		sum_a = '0;
		sum_c = '0;
		for (int k = 0; k < OCTAVES; k++) begin
			sum_a = sum_a + 72'(ma_s16[k]);
			sum_c = sum_c + 72'(mc_s16[k]);
		end
		for (int i = 0; i < 3; i++) begin
			res[i] = rshr(72'(acc_s20[i]), 30);
			if (res[i] > 72'sd2147483647) begin
				sat[i] = 32'h7FFF_FFFF;
			end else if (res[i] < -72'sd2147483648) begin
				sat[i] = 32'h8000_0000;
			end else begin
				sat[i] = res[i][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			along_s17 <= 32'(rshr(sum_a, 16));
			cross_s17 <= 32'(rshr(sum_c, 16));
			ta_s18 <= 34'(rshr(72'($signed({1'b0, swing_q}) * along_s17), 30));
			tc_s18 <= 33'(rshr(72'($signed({1'b0, swing_q}) * cross_s17), 31));
			for (int i = 0; i < 3; i++) begin
				a_s19[i] <= $signed(u_q[i]) * $signed({1'b0, str_q});
				b_s19[i] <= $signed(u_q[i]) * ta_s18;
				c_s19[i] <= $signed(w_q[i]) * tc_s18;
				acc_s20[i] <= 58'((72'(a_s19[i]) <<< 8) + rshr(72'(b_s19[i]), 8)
					+ rshr(72'(c_s19[i]), 8));
				m_tdata[32*i +: 32] <= sat[i];
			end
		end
	end

endmodule
`default_nettype wire

@@ tb/wind_gust_vector_field_unit_test.sv @@
// testbench for the wind gust vector field unit: random stream checked against a local predictor
`default_nettype none
module wind_gust_vector_field_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import wgv_pkg::*;

	localparam longint LIMIT_CYCLES = 400000;
	localparam longint UNIT_Q30 = 64'sd1073741824;
	localparam longint YLIM_Q30 = 64'sd1063004406;
	localparam longint QTURN_Q48 = 64'sd70368744177664;
	localparam int HOLD_AT = 360;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [127:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_idx = '0;
	logic [31:0] cfg_data = '0;

	wind_gust_vector_field_unit uut (.*);

	// local copy of the register file
	longint dir_v [3];
	longint strength_r, gust_r, seed_r;

	logic [127:0] pending_q [$];
	logic [95:0] wind_expected_q [$];
	int mismatch_count = 0;
	longint cycle_count = 0;
	int accepted_count = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int send_gap = 0, recv_gap = 0;

	initial forever #1 clk = ~clk;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("** wind_gust_vector_field_unit: FAILED **");
			$finish;
		end
	end

	function automatic longint round_shift(longint v, int sh);
		longint half;
		half = 64'sd1 <<< (sh - 1);
		if (v < 0)
			return -longint'((longint'(-v) + half) >>> sh);
		return (v + half) >>> sh;
	endfunction

	function automatic longint int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	task automatic unit_vector(input longint v [3], output longint u [3]);
		longint unsigned m [3];
		longint unsigned mx, n, s;
		mx = 0;
		n = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = v[i] < 0 ? -v[i] : v[i];
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) begin
			u = '{UNIT_Q30, 0, 0};
			return;
		end
		while (mx < (64'd1 << 30)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++) m[i] <<= 1;
		end
		for (int i = 0; i < 3; i++) n += m[i] * m[i];
		s = int_sqrt(n);
		for (int i = 0; i < 3; i++) begin
			longint q;
			q = longint'(((m[i] << 30) + (s >> 1)) / s);
			u[i] = v[i] < 0 ? -q : q;
		end
	endtask

	function automatic longint sine_of_turn(logic [31:0] t);
		logic [1:0] quad;
		longint unsigned r, x, x2, acc;
		longint unsigned divs [5];
		divs = '{110, 72, 42, 20, 6};
		quad = t[31:30];
		r = t[29:0];
		acc = UNIT_Q30;
		if (quad[0]) r = UNIT_Q30 - r;
		x = (r * HALF_PI_Q30 + (64'd1 << 29)) >> 30;
		x2 = (x * x + (64'd1 << 29)) >> 30;
		for (int i = 0; i < 5; i++)
			acc = UNIT_Q30 - (((x2 * acc + (64'd1 << 29)) >> 30) / divs[i]);
		acc = (x * acc + (64'd1 << 29)) >> 30;
		if (acc > UNIT_Q30) acc = UNIT_Q30;
		return quad[1] ? -longint'(acc) : longint'(acc);
	endfunction

	function automatic longint gust_sum(longint p [3], longint unsigned t,
			longint unsigned offset);
		longint sum;
		longint unsigned a;
		sum = 0;
		for (int k = 0; k < OCTAVES; k++) begin
			a = longint'(seed_r) * 64'd683565276 + offset;
			for (int j = 0; j < 3; j++) a += longint'(p[j]) * longint'(FREQ[k][j]);
			a += t * longint'(SPEED[k]);
			sum += longint'(AMP[k]) * sine_of_turn(a[47:16]);
		end
		return round_shift(sum, 16);
	endfunction

	task automatic predict_wind(input logic [127:0] item);
		longint p [3], u [3], c [3], w [3];
		longint g, swing, along, side, ta, tc, acc, r;
		logic [95:0] res;
		for (int i = 0; i < 3; i++) p[i] = longint'($signed(item[32*i +: 32]));
		unit_vector(dir_v, u);
		if ((u[1] < 0 ? -u[1] : u[1]) < YLIM_Q30) c = '{-u[2], 0, u[0]};
		else c = '{0, u[2], -u[1]};
		unit_vector(c, w);
		g = gust_r > 65536 ? 65536 : gust_r;
		swing = strength_r * g;
		along = gust_sum(p, item[127:96], 0);
		side = gust_sum(p, item[127:96], QTURN_Q48);
		ta = round_shift(swing * along, 30);
		tc = round_shift(swing * side, 31);
		for (int i = 0; i < 3; i++) begin
			acc = u[i] * strength_r * 256 + round_shift(u[i] * ta, 8)
				+ round_shift(w[i] * tc, 8);
			r = round_shift(acc, 30);
			if (r > 64'sd2147483647) r = 64'sd2147483647;
			if (r < -64'sd2147483648) r = -64'sd2147483648;
			res[32*i +: 32] = r[31:0];
		end
		wind_expected_q.push_back(res);
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cycle_count);
		mismatch_count++;
	endtask

	// driver
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			predict_wind(s_tdata);
			accepted_count <= accepted_count + 1;
			send_gap <= $urandom_range(0, 6);
			if (pending_q.size() > 0 && $urandom_range(0, 6) == 0) begin
				s_tdata <= pending_q.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end else if (!s_tvalid && arst_n) begin
			if (send_gap > 0) send_gap <= send_gap - 1;
			else if (pending_q.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_q.pop_front();
			end
		end
	end

	// long receiver hold once the stream is well under way
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && accepted_count == HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (wind_expected_q.size() == 0) begin
				report("unexpected item", m_tdata[31:0], '0);
			end else begin
				logic [95:0] e;
				e = wind_expected_q.pop_front();
				if (m_tdata[31:0] !== e[31:0]) report("wind_x", m_tdata[31:0], e[31:0]);
				if (m_tdata[63:32] !== e[63:32]) report("wind_y", m_tdata[63:32], e[63:32]);
				if (m_tdata[95:64] !== e[95:64]) report("wind_z", m_tdata[95:64], e[95:64]);
			end
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
		end else if (m_tready && m_tvalid) begin
			recv_gap <= $urandom_range(0, 6);
			m_tready <= ($urandom_range(0, 6) == 0);
		end else if (!m_tready) begin
			if (recv_gap > 0) recv_gap <= recv_gap - 1;
			else m_tready <= 1'b1;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_DIR_X: dir_v[0] = longint'($signed(val));
			CFG_DIR_Y: dir_v[1] = longint'($signed(val));
			CFG_DIR_Z: dir_v[2] = longint'($signed(val));
			CFG_STRENGTH: strength_r = val[15:0];
			CFG_GUST: gust_r = val[16:0];
			CFG_SEED: seed_r = longint'($signed(val));
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_q.size() > 0 || s_tvalid || wind_expected_q.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [127:0] rand_item();
		return {rand_word(), rand_word(), rand_word(), rand_word()};
	endfunction

	initial begin
		dir_v = '{65536, 0, 0};
		strength_r = 256;
		gust_r = 0;
		seed_r = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes under reset settings, zero gustiness
		pending_q.push_back('0);
		pending_q.push_back({4{32'hffff_ffff}});
		pending_q.push_back({4{32'h8000_0000}});
		pending_q.push_back({4{32'h7fff_ffff}});
		pending_q.push_back({32'h0001_0000, 32'h0, 32'h0, 32'h0});
		drain();

		// full gust, maximal strength: saturation and gust above one
		write_reg(CFG_STRENGTH, 32'hffff);
		write_reg(CFG_GUST, 32'h1ffff);
		write_reg(CFG_SEED, 32'h7fff_ffff);
		write_reg(3'd7, 32'h1234_5678);
		for (int i = 0; i < 8; i++) pending_q.push_back(rand_item());
		drain();

		// zero direction, then a vertical direction
		write_reg(CFG_DIR_X, 0);
		write_reg(CFG_DIR_Y, 0);
		write_reg(CFG_DIR_Z, 0);
		write_reg(CFG_GUST, 65536);
		for (int i = 0; i < 4; i++) pending_q.push_back(rand_item());
		drain();
		write_reg(CFG_DIR_Y, 32'h8000_0000);
		write_reg(CFG_SEED, 32'h8000_0000);
		for (int i = 0; i < 4; i++) pending_q.push_back(rand_item());
		drain();

		// random phases with random settings
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(CFG_DIR_X, rand_word());
			write_reg(CFG_DIR_Y, $urandom_range(0, 3) == 0 ? rand_word() : 32'($urandom_range(0, 4096)));
			write_reg(CFG_DIR_Z, rand_word());
			write_reg(CFG_STRENGTH, $urandom_range(0, 1) ? 32'hffff : $urandom_range(0, 65535));
			write_reg(CFG_GUST, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 131071));
			write_reg(CFG_SEED, rand_word());
			for (int i = 0; i < 83; i++) pending_q.push_back(rand_item());
			drain();
		end

		if (mismatch_count == 0) begin
			$display("** wind_gust_vector_field_unit: PASSED **");
		end else begin
			$display("** wind_gust_vector_field_unit: FAILED **");
		end
		$finish;
	end

	// leftover expectations are caught because drain waits for them; the cycle limit ends a hang
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/wgv_pkg.sv
rtl/wgv_norm.sv
rtl/wgv_sine.sv
rtl/wind_gust_vector_field_unit.sv
tb/wind_gust_vector_field_unit_test.sv
